@@ design/c8ic_pkg.sv @@
// Shared types and constants for the CHIP-8 instruction core.
`default_nettype none
package c8ic_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_EXEC  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_ROW   = 2'd3
  } func_t;

  localparam logic [11:0] ADDR_MASK    = 12'hFFF;
  localparam logic [7:0]  BIT_MSB      = 8'h80;
  localparam logic [15:0] OP_CLS       = 16'h00E0;
  localparam logic [15:0] OP_RET       = 16'h00EE;
  localparam logic [7:0]  KK_SKP       = 8'h9E;
  localparam logic [7:0]  KK_SKNP      = 8'hA1;
  localparam logic [7:0]  KK_GETDELAY  = 8'h07;
  localparam logic [7:0]  KK_WAITKEY   = 8'h0A;
  localparam logic [7:0]  KK_SETDELAY  = 8'h15;
  localparam logic [7:0]  KK_SETSOUND  = 8'h18;
  localparam logic [7:0]  KK_ADDI      = 8'h1E;
  localparam logic [7:0]  KK_FONT      = 8'h29;
  localparam logic [7:0]  KK_BCD       = 8'h33;
  localparam logic [7:0]  KK_STORE     = 8'h55;
  localparam logic [7:0]  KK_LOAD      = 8'h65;

  localparam logic [11:0] FONT_RESET   = 12'd80;
  localparam int unsigned FONT_BYTES   = 80;

  localparam logic [0:0] REG_PROGRAM_START = 1'b0;
  localparam logic [0:0] REG_FONT_BASE     = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_CLS,
    ST_DRAW_RD,
    ST_DRAW_ROW,
    ST_DRAW_WR,
    ST_BCD,
    ST_STORE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_MEM_RD,
    ST_MEM_WAIT,
    ST_ROW_RD,
    ST_ROW_WAIT,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Memory access request from the sequencer to the memory unit.
  typedef struct packed {
    logic        mem_we;
    logic [11:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic        scr_we;
    logic [4:0]  scr_addr;
    logic [63:0] scr_wdata;
  } mem_req_t;

  function automatic logic [7:0] glyph_byte(input logic [6:0] i);
    logic [7:0] g [0:79];
    g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
          8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
          8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
          8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
          8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
          8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
          8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
          8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
    return (i < 7'd80) ? g[i] : 8'h00;
  endfunction

endpackage
`default_nettype wire

@@ design/c8ic_mem.sv @@
// Main memory and screen memory, with registered reads.
`default_nettype none
module c8ic_mem (
  input  wire logic              clk,
  input  wire c8ic_pkg::mem_req_t req,
  output logic [7:0]             mem_rdata,
  output logic [63:0]            scr_rdata
);

  logic [7:0]  main_ram [0:4095];
  logic [63:0] scr_ram  [0:31];

  always_ff @(posedge clk) begin
    if (req.mem_we) begin
      main_ram[req.mem_addr] <= req.mem_wdata;
    end
    mem_rdata <= main_ram[req.mem_addr];
  end

  always_ff @(posedge clk) begin
    if (req.scr_we) begin
      scr_ram[req.scr_addr] <= req.scr_wdata;
    end
    scr_rdata <= scr_ram[req.scr_addr];
  end

endmodule
`default_nettype wire

@@ design/chip8_instruction_core.sv @@
// Top level of the CHIP-8 instruction core: sequencer, registers and memories.
// Memory write, byte read and row read each pass through a read state and a wait state;
//   execute fetches, decodes and finishes, with extra steps per sprite row for a draw,
//   per screen row for a clear, per digit for BCD and per register for Fx55 and Fx65.
// Throughput: one item at a time; the result holds until taken and the core is ready
//   again the cycle after. Reset: a clearing pass zeroes main memory, loads the font at
//   address 80 and clears the 32 screen rows; no item is accepted meanwhile.
`default_nettype none
module chip8_instruction_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [11:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic [4:0]  row_select,
  input  wire logic [15:0] keys_pressed,
  input  wire logic [7:0]  random_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      read_data,
  output logic [11:0]      pc_now,
  output logic [15:0]      executed_opcode,
  output logic             unknown_opcode,
  output logic             waiting_key,
  output logic             sound_on,
  output logic             screen_changed
);

  localparam int unsigned SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SP_W-1:0] SP_TOP = SP_W'(STACK_DEPTH - 1);

  c8ic_pkg::state_t   state, state_next;
  c8ic_pkg::mem_req_t req;
  logic [7:0]  mem_rdata;
  logic [63:0] scr_rdata;

  logic [11:0] font_base, pc;
  logic [7:0]  v [0:15];
  logic [15:0] index_reg;
  logic [11:0] stack [0:STACK_DEPTH-1];
  logic [SP_W-1:0] sp;
  logic [7:0]  delay_count, sound_count;

  // captured item
  logic [1:0]  f_func;
  logic [11:0] f_addr;
  logic [7:0]  f_wdata;
  logic [4:0]  f_row;
  logic [15:0] f_keys;
  logic [7:0]  f_rnd;

  logic [15:0] op;
  logic [12:0] cnt;
  logic [5:0]  sprite_sh;
  logic [63:0] sprite_mask;
  logic [4:0]  cur_row;
  logic        unk, wait_k, chg;

  c8ic_mem u_mem (.clk(clk), .req(req), .mem_rdata(mem_rdata), .scr_rdata(scr_rdata));

  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn;
  assign x   = op[11:8];
  assign y   = op[7:4];
  assign n   = op[3:0];
  assign kk  = op[7:0];
  assign nnn = op[11:0];
  assign vx  = v[x];
  assign vy  = v[y];

  // full word during decode, while the low byte is still on the read port
  logic [15:0] op_dec;
  assign op_dec = {op[15:8], mem_rdata};

  assign in_ready = (state == c8ic_pkg::ST_IDLE);

  // sprite byte placed at column vx, wrapping within the row
  logic [63:0] spr_wide;
  logic [63:0] spr_rot;
  always_comb begin
    spr_wide = {mem_rdata, 56'd0};
    spr_rot  = (spr_wide >> sprite_sh) | (spr_wide << (7'd64 - {1'b0, sprite_sh}));
  end

  logic [8:0] bcd_hund;
  logic [7:0] bcd_rem, bcd_tens, bcd_ones;
  always_comb begin
    bcd_hund = (vx >= 8'd200) ? 9'd2 : ((vx >= 8'd100) ? 9'd1 : 9'd0);
    bcd_rem  = vx - 8'(bcd_hund * 9'd100);
    bcd_tens = 8'((16'(bcd_rem) * 16'd205) >> 11);
    bcd_ones = bcd_rem - 8'(bcd_tens * 8'd10);
  end

  logic [3:0] low_key;
  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (f_keys[k]) low_key = 4'(k);
    end
  end

  always_comb begin
    state_next = state;
    req = '0;
    unique case (state)
      c8ic_pkg::ST_INIT: begin
        req.mem_we = 1'b1;
        req.mem_addr = cnt[11:0];
        req.mem_wdata = (cnt[11:0] >= c8ic_pkg::FONT_RESET &&
                         cnt[11:0] < c8ic_pkg::FONT_RESET + 12'(c8ic_pkg::FONT_BYTES))
                        ? c8ic_pkg::glyph_byte(7'(cnt[11:0] - c8ic_pkg::FONT_RESET)) : 8'h00;
        req.scr_we = (cnt < 13'd32);
        req.scr_addr = cnt[4:0];
        if (cnt == 13'd4095) state_next = c8ic_pkg::ST_IDLE;
      end
      c8ic_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (c8ic_pkg::func_t'(func))
            c8ic_pkg::FUNC_WRITE: state_next = c8ic_pkg::ST_MEM_RD;
            c8ic_pkg::FUNC_READ:  state_next = c8ic_pkg::ST_MEM_RD;
            c8ic_pkg::FUNC_ROW:   state_next = c8ic_pkg::ST_ROW_RD;
            default:              state_next = c8ic_pkg::ST_FETCH_HI;
          endcase
        end
      end
      c8ic_pkg::ST_MEM_RD: begin
        req.mem_addr = f_addr;
        req.mem_we = (f_func == c8ic_pkg::FUNC_WRITE);
        req.mem_wdata = f_wdata;
        state_next = c8ic_pkg::ST_MEM_WAIT;
      end
      c8ic_pkg::ST_MEM_WAIT: state_next = c8ic_pkg::ST_OUT;
      c8ic_pkg::ST_ROW_RD: begin
        req.scr_addr = f_row;
        state_next = c8ic_pkg::ST_ROW_WAIT;
      end
      c8ic_pkg::ST_ROW_WAIT: state_next = c8ic_pkg::ST_OUT;
      c8ic_pkg::ST_FETCH_HI: begin
        req.mem_addr = pc;
        state_next = c8ic_pkg::ST_FETCH_LO;
      end
      c8ic_pkg::ST_FETCH_LO: begin
        req.mem_addr = pc + 12'd1;
        state_next = c8ic_pkg::ST_DECODE;
      end
      c8ic_pkg::ST_DECODE: begin
        state_next = c8ic_pkg::ST_FINISH;
        if (op_dec == c8ic_pkg::OP_CLS) state_next = c8ic_pkg::ST_CLS;
        else if (op_dec[15:12] == 4'hD)
          state_next = (op_dec[3:0] == 4'd0) ? c8ic_pkg::ST_FINISH : c8ic_pkg::ST_DRAW_RD;
        else if (op_dec[15:12] == 4'hF && op_dec[7:0] == c8ic_pkg::KK_BCD)
          state_next = c8ic_pkg::ST_BCD;
        else if (op_dec[15:12] == 4'hF && op_dec[7:0] == c8ic_pkg::KK_STORE)
          state_next = c8ic_pkg::ST_STORE;
        else if (op_dec[15:12] == 4'hF && op_dec[7:0] == c8ic_pkg::KK_LOAD)
          state_next = c8ic_pkg::ST_LOAD_RD;
      end
      c8ic_pkg::ST_CLS: begin
        // read and clear row cnt; its old contents arrive on the next cycle
        req.scr_addr = cnt[4:0];
        req.scr_we = (cnt != 13'd32);
        if (cnt == 13'd32) state_next = c8ic_pkg::ST_FINISH;
      end
      c8ic_pkg::ST_DRAW_RD: begin
        req.mem_addr = 12'(index_reg + 16'(cnt[3:0]));
        req.scr_addr = cur_row;
        state_next = c8ic_pkg::ST_DRAW_ROW;
      end
      c8ic_pkg::ST_DRAW_ROW: begin
        req.scr_addr = cur_row;
        state_next = c8ic_pkg::ST_DRAW_WR;
      end
      c8ic_pkg::ST_DRAW_WR: begin
        req.scr_we = 1'b1;
        req.scr_addr = cur_row;
        req.scr_wdata = scr_rdata ^ sprite_mask;
        state_next = (cnt[3:0] + 4'd1 == n) ? c8ic_pkg::ST_FINISH : c8ic_pkg::ST_DRAW_RD;
      end
      c8ic_pkg::ST_BCD: begin
        req.mem_we = 1'b1;
        req.mem_addr = 12'(index_reg + 16'(cnt[1:0]));
        req.mem_wdata = (cnt[1:0] == 2'd0) ? 8'(bcd_hund) :
                        ((cnt[1:0] == 2'd1) ? bcd_tens : bcd_ones);
        if (cnt[1:0] == 2'd2) state_next = c8ic_pkg::ST_FINISH;
      end
      c8ic_pkg::ST_STORE: begin
        req.mem_we = 1'b1;
        req.mem_addr = 12'(index_reg + 16'(cnt[3:0]));
        req.mem_wdata = v[cnt[3:0]];
        if (cnt[3:0] == x) state_next = c8ic_pkg::ST_FINISH;
      end
      c8ic_pkg::ST_LOAD_RD: begin
        req.mem_addr = 12'(index_reg + 16'(cnt[3:0]));
        state_next = c8ic_pkg::ST_LOAD_WR;
      end
      c8ic_pkg::ST_LOAD_WR:
        state_next = (cnt[3:0] == x) ? c8ic_pkg::ST_FINISH : c8ic_pkg::ST_LOAD_RD;
      c8ic_pkg::ST_FINISH: state_next = c8ic_pkg::ST_OUT;
      c8ic_pkg::ST_OUT: if (out_ready) state_next = c8ic_pkg::ST_IDLE;
      default: state_next = c8ic_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = (state == c8ic_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c8ic_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      font_base <= c8ic_pkg::FONT_RESET;
      pc <= 12'd512;
      index_reg <= '0;
      sp <= '0;
      delay_count <= '0;
      sound_count <= '0;
      for (int i = 0; i < 16; i++) v[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == c8ic_pkg::REG_PROGRAM_START) begin
          pc <= cfg_data;
        end else begin
          font_base <= cfg_data;
        end
      end
      unique case (state)
        c8ic_pkg::ST_INIT: cnt <= cnt + 13'd1;
        c8ic_pkg::ST_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            f_func <= func; f_addr <= address; f_wdata <= write_data;
            f_row <= row_select; f_keys <= keys_pressed; f_rnd <= random_value;
            read_data <= '0; executed_opcode <= '0;
            unknown_opcode <= 1'b0; waiting_key <= 1'b0; screen_changed <= 1'b0;
            unk <= 1'b0; wait_k <= 1'b0; chg <= 1'b0;
          end
        end
        c8ic_pkg::ST_MEM_WAIT:
          if (f_func == c8ic_pkg::FUNC_READ) read_data <= {56'd0, mem_rdata};
        c8ic_pkg::ST_ROW_WAIT: read_data <= scr_rdata;
        c8ic_pkg::ST_FETCH_LO: begin
          op[15:8] <= mem_rdata;
          pc <= pc + 12'd2;
        end
        c8ic_pkg::ST_DECODE: begin
          op[7:0] <= mem_rdata;
        end
        c8ic_pkg::ST_CLS: begin
          cnt <= cnt + 13'd1;
          if (cnt != 13'd0 && scr_rdata != 64'd0) chg <= 1'b1;
        end
        c8ic_pkg::ST_DRAW_RD: ;
        c8ic_pkg::ST_DRAW_ROW: sprite_mask <= spr_rot;
        c8ic_pkg::ST_DRAW_WR: begin
          if ((scr_rdata & sprite_mask) != 64'd0) v[15] <= 8'd1;
          if (sprite_mask != 64'd0) chg <= 1'b1;
          cnt <= cnt + 13'd1;
          cur_row <= cur_row + 5'd1;
        end
        c8ic_pkg::ST_BCD, c8ic_pkg::ST_STORE: cnt <= cnt + 13'd1;
        c8ic_pkg::ST_LOAD_RD: ;
        c8ic_pkg::ST_LOAD_WR: begin
          v[cnt[3:0]] <= mem_rdata;
          cnt <= cnt + 13'd1;
        end
        c8ic_pkg::ST_FINISH: begin
          if (delay_count != 8'd0) delay_count <= delay_count - 8'd1;
          if (sound_count != 8'd0) sound_count <= sound_count - 8'd1;
          executed_opcode <= op;
          unknown_opcode <= unk;
          waiting_key <= wait_k;
          screen_changed <= chg;
          sound_on <= (sound_count > 8'd1);
        end
        c8ic_pkg::ST_OUT: ;
        default: ;
      endcase
      if (state == c8ic_pkg::ST_MEM_WAIT || state == c8ic_pkg::ST_ROW_WAIT) begin
        sound_on <= (sound_count != 8'd0);
      end
      // instructions that need no further memory steps execute at decode, with the low byte just read
      if (state == c8ic_pkg::ST_DECODE) begin
        sprite_sh <= 6'(v[op[11:8]]);
        cur_row <= 5'(v[mem_rdata[7:4]]);
        begin : exec
          logic [15:0] o;
          logic [7:0]  a, b, k8;
          logic [8:0]  s;
          o = {op[15:8], mem_rdata};
          a = v[o[11:8]];
          b = v[o[7:4]];
          k8 = o[7:0];
          s = {1'b0, a} + {1'b0, b};
          case (o[15:12])
            4'h0: begin
              if (o == c8ic_pkg::OP_RET) begin
                pc <= stack[(sp == '0) ? SP_TOP : sp - 1'b1];
                sp <= (sp == '0) ? SP_TOP : sp - 1'b1;
              end else if (o != c8ic_pkg::OP_CLS) begin
                unk <= 1'b1;
              end
            end
            4'h1: pc <= o[11:0];
            4'h2: begin
              stack[sp] <= pc;
              sp <= (sp == SP_TOP) ? '0 : sp + 1'b1;
              pc <= o[11:0];
            end
            4'h3: if (a == k8) pc <= pc + 12'd2;
            4'h4: if (a != k8) pc <= pc + 12'd2;
            4'h5: if (a == b) pc <= pc + 12'd2;
            4'h6: v[o[11:8]] <= k8;
            4'h7: v[o[11:8]] <= a + k8;
            4'h8: begin
              case (o[3:0])
                4'h0: v[o[11:8]] <= b;
                4'h1: v[o[11:8]] <= a | b;
                4'h2: v[o[11:8]] <= a & b;
                4'h3: v[o[11:8]] <= a ^ b;
                4'h4: begin v[15] <= {7'd0, s[8]}; v[o[11:8]] <= s[7:0]; end
                4'h5: begin v[15] <= {7'd0, a >= b}; v[o[11:8]] <= a - b; end
                4'h6: begin v[15] <= {7'd0, a[0]}; v[o[11:8]] <= a >> 1; end
                4'h7: begin v[15] <= {7'd0, b >= a}; v[o[11:8]] <= b - a; end
                4'hE: begin v[15] <= {7'd0, a[7]}; v[o[11:8]] <= a << 1; end
                default: unk <= 1'b1;
              endcase
            end
            4'h9: if (a != b) pc <= pc + 12'd2;
            4'hA: index_reg <= {4'd0, o[11:0]};
            4'hB: pc <= o[11:0] + {4'd0, v[0]};
            4'hC: v[o[11:8]] <= f_rnd & k8;
            4'hD: v[15] <= 8'd0;
            4'hE: begin
              if (k8 == c8ic_pkg::KK_SKP) begin
                if (f_keys[a[3:0]]) pc <= pc + 12'd2;
              end else if (k8 == c8ic_pkg::KK_SKNP) begin
                if (!f_keys[a[3:0]]) pc <= pc + 12'd2;
              end else begin
                unk <= 1'b1;
              end
            end
            default: begin
              case (k8)
                c8ic_pkg::KK_GETDELAY: v[o[11:8]] <= delay_count;
                c8ic_pkg::KK_WAITKEY: begin
                  if (f_keys != 16'd0) v[o[11:8]] <= {4'd0, low_key};
                  else begin pc <= pc - 12'd2; wait_k <= 1'b1; end
                end
                c8ic_pkg::KK_SETDELAY: delay_count <= a;
                c8ic_pkg::KK_SETSOUND: sound_count <= a;
                c8ic_pkg::KK_ADDI: index_reg <= index_reg + {8'd0, a};
                c8ic_pkg::KK_FONT:
                  index_reg <= {4'd0, font_base} + 16'({a[3:0], 2'b00}) + {12'd0, a[3:0]};
                c8ic_pkg::KK_BCD, c8ic_pkg::KK_STORE, c8ic_pkg::KK_LOAD: ;
                default: unk <= 1'b1;
              endcase
            end
          endcase
        end
      end
      if (state == c8ic_pkg::ST_FINISH) begin
        pc_now <= pc;
        if (op[15:12] == 4'hF && op[7:0] == c8ic_pkg::KK_SETSOUND) begin
          sound_on <= (v[op[11:8]] > 8'd1);
        end
      end
      if (state == c8ic_pkg::ST_MEM_WAIT || state == c8ic_pkg::ST_ROW_WAIT) pc_now <= pc;
    end
  end

  // A draw row write always follows a row read, with the sprite row state between them.
  assert property (@(posedge clk) disable iff (rst)
    state == c8ic_pkg::ST_DRAW_WR |-> $past(state, 2) == c8ic_pkg::ST_DRAW_RD)
    else $error("draw write without row read");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("ready while holding a result");
  assert property (@(posedge clk) disable iff (rst)
    state == c8ic_pkg::ST_DECODE |-> $past(state, 2) == c8ic_pkg::ST_FETCH_HI)
    else $error("decode without fetch");

endmodule
`default_nettype wire

@@ test/c8ic_checker.sv @@
// Predictor and result checker for the CHIP-8 instruction core.
`timescale 1ns / 1ps
module c8ic_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [11:0] address,
  input  logic [7:0]  write_data,
  input  logic [4:0]  row_select,
  input  logic [15:0] keys_pressed,
  input  logic [7:0]  random_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] read_data,
  input  logic [11:0] pc_now,
  input  logic [15:0] executed_opcode,
  input  logic        unknown_opcode,
  input  logic        waiting_key,
  input  logic        sound_on,
  input  logic        screen_changed,
  output int          errors,
  output int          pending,
  output int          results_seen
);

  typedef struct {
    logic [63:0] rdata;
    logic [11:0] pc;
    logic [15:0] op;
    logic        unk;
    logic        wkey;
    logic        snd;
    logic        chg;
  } core_result_t;

  localparam logic [7:0] HEX_FONT [0:79] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};

  logic [7:0]  mem [0:4095];
  logic [63:0] scr [0:31];
  logic [7:0]  v [0:15];
  logic [11:0] stk [0:15];
  logic [15:0] ireg;
  logic [11:0] pc, pstart, fbase;
  logic [3:0]  sp;
  logic [7:0]  dly, snd;
  core_result_t expected_q [$];

  task automatic clear_machine();
    for (int a = 0; a < 4096; a++) mem[a] = 8'h00;
    for (int a = 0; a < 80; a++) mem[c8ic_pkg::FONT_RESET + a] = HEX_FONT[a];
    for (int r = 0; r < 32; r++) scr[r] = '0;
    for (int r = 0; r < 16; r++) begin
      v[r] = '0;
      stk[r] = '0;
    end
    ireg = '0;
    pstart = 12'd512;
    fbase = c8ic_pkg::FONT_RESET;
    pc = pstart;
    sp = '0;
    dly = '0;
    snd = '0;
  endtask

  // Run one instruction on the model; return flags through the result.
  task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                 inout core_result_t res);
    logic [15:0] op;
    logic [3:0]  x, y;
    logic [7:0]  kk, vx, vy, b;
    logic [11:0] nnn, base;
    logic [8:0]  sum;
    logic [5:0]  col;
    logic [4:0]  row;
    bit          found;
    op = {mem[pc], mem[pc + 12'd1]};
    pc = pc + 12'd2;
    x = op[11:8];
    y = op[7:4];
    kk = op[7:0];
    nnn = op[11:0];
    vx = v[x];
    vy = v[y];
    base = ireg[11:0];
    res.op = op;
    case (op[15:12])
      4'h0: begin
        if (op == c8ic_pkg::OP_CLS) begin
          for (int r = 0; r < 32; r++) begin
            if (scr[r] != 0) res.chg = 1'b1;
            scr[r] = '0;
          end
        end else if (op == c8ic_pkg::OP_RET) begin
          sp = sp - 4'd1;
          pc = stk[sp];
        end else begin
          res.unk = 1'b1;
        end
      end
      4'h1: pc = nnn;
      4'h2: begin
        stk[sp] = pc;
        sp = sp + 4'd1;
        pc = nnn;
      end
      4'h3: if (vx == kk) pc = pc + 12'd2;
      4'h4: if (vx != kk) pc = pc + 12'd2;
      4'h5: if (vx == vy) pc = pc + 12'd2;
      4'h6: v[x] = kk;
      4'h7: v[x] = vx + kk;
      4'h8: begin
        case (op[3:0])
          4'h0: v[x] = vy;
          4'h1: v[x] = vx | vy;
          4'h2: v[x] = vx & vy;
          4'h3: v[x] = vx ^ vy;
          4'h4: begin
            sum = {1'b0, vx} + {1'b0, vy};
            v[15] = {7'd0, sum[8]};
            v[x] = sum[7:0];
          end
          4'h5: begin
            v[15] = {7'd0, vx >= vy};
            v[x] = vx - vy;
          end
          4'h6: begin
            v[15] = {7'd0, vx[0]};
            v[x] = vx >> 1;
          end
          4'h7: begin
            v[15] = {7'd0, vy >= vx};
            v[x] = vy - vx;
          end
          4'hE: begin
            v[15] = {7'd0, vx[7]};
            v[x] = vx << 1;
          end
          default: res.unk = 1'b1;
        endcase
      end
      4'h9: if (vx != vy) pc = pc + 12'd2;
      4'hA: ireg = {4'h0, nnn};
      4'hB: pc = nnn + {4'h0, v[0]};
      4'hC: v[x] = rnd & kk;
      4'hD: begin
        v[15] = '0;
        for (int r = 0; r < op[3:0]; r++) begin
          b = mem[base + 12'(r)];
          row = vy[4:0] + 5'(r);
          for (int c = 0; c < 8; c++) begin
            if (b & (c8ic_pkg::BIT_MSB >> c)) begin
              col = vx[5:0] + 6'(c);
              if (scr[row][63 - col]) v[15] = 8'd1;
              scr[row][63 - col] = ~scr[row][63 - col];
              res.chg = 1'b1;
            end
          end
        end
      end
      4'hE: begin
        if (kk == c8ic_pkg::KK_SKP) begin
          if (keys[vx[3:0]]) pc = pc + 12'd2;
        end else if (kk == c8ic_pkg::KK_SKNP) begin
          if (!keys[vx[3:0]]) pc = pc + 12'd2;
        end else begin
          res.unk = 1'b1;
        end
      end
      default: begin
        case (kk)
          c8ic_pkg::KK_GETDELAY: v[x] = dly;
          c8ic_pkg::KK_WAITKEY: begin
            if (keys != 0) begin
              found = 0;
              for (int k = 0; k < 16; k++) begin
                if (keys[k] && !found) begin
                  v[x] = 8'(k);
                  found = 1;
                end
              end
            end else begin
              pc = pc - 12'd2;
              res.wkey = 1'b1;
            end
          end
          c8ic_pkg::KK_SETDELAY: dly = vx;
          c8ic_pkg::KK_SETSOUND: snd = vx;
          c8ic_pkg::KK_ADDI: ireg = ireg + {8'h00, vx};
          c8ic_pkg::KK_FONT: ireg = {4'h0, fbase} + 16'(5 * vx[3:0]);
          c8ic_pkg::KK_BCD: begin
            mem[base] = vx / 100;
            mem[base + 12'd1] = (vx / 10) % 10;
            mem[base + 12'd2] = vx % 10;
          end
          c8ic_pkg::KK_STORE: for (int i = 0; i <= x; i++) mem[base + 12'(i)] = v[i];
          c8ic_pkg::KK_LOAD: for (int i = 0; i <= x; i++) v[i] = mem[base + 12'(i)];
          default: res.unk = 1'b1;
        endcase
      end
    endcase
    if (dly != 0) dly = dly - 8'd1;
    if (snd != 0) snd = snd - 8'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    core_result_t res, want;
    if (rst) begin
      clear_machine();
      expected_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == c8ic_pkg::REG_PROGRAM_START) begin
          pstart = cfg_data;
          pc = cfg_data;
        end else begin
          fbase = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        res = '{default: '0};
        case (c8ic_pkg::func_t'(func))
          c8ic_pkg::FUNC_WRITE: mem[address] = write_data;
          c8ic_pkg::FUNC_READ:  res.rdata = {56'd0, mem[address]};
          c8ic_pkg::FUNC_ROW:   res.rdata = scr[row_select];
          default:              run_instruction(keys_pressed, random_value, res);
        endcase
        res.pc = pc;
        res.snd = (snd != 0);
        expected_q.push_back(res);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no item outstanding", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (read_data !== want.rdata) report_mismatch("read_data", read_data, want.rdata);
          if (pc_now !== want.pc) report_mismatch("pc_now", pc_now, want.pc);
          if (executed_opcode !== want.op)
            report_mismatch("executed_opcode", executed_opcode, want.op);
          if (unknown_opcode !== want.unk)
            report_mismatch("unknown_opcode", unknown_opcode, want.unk);
          if (waiting_key !== want.wkey)
            report_mismatch("waiting_key", waiting_key, want.wkey);
          if (sound_on !== want.snd) report_mismatch("sound_on", sound_on, want.snd);
          if (screen_changed !== want.chg)
            report_mismatch("screen_changed", screen_changed, want.chg);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ test/tb_chip8_instruction_core.sv @@
// Stimulus and verdict for the CHIP-8 instruction core.
`timescale 1ns / 1ps
module tb_chip8_instruction_core;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = c8ic_pkg::REG_PROGRAM_START;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = c8ic_pkg::FUNC_WRITE;
  logic [11:0] address = '0;
  logic [7:0]  write_data = '0;
  logic [4:0]  row_select = '0;
  logic [15:0] keys_pressed = '0;
  logic [7:0]  random_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] read_data;
  logic [11:0] pc_now;
  logic [15:0] executed_opcode;
  logic        unknown_opcode, waiting_key, sound_on, screen_changed;
  int          errors, pending, results_seen;
  int          items_sent = 0;
  bit          calm = 1'b0;

  always #4 clk = ~clk;

  chip8_instruction_core i_dut (.*);

  c8ic_checker i_checker (.*);

  task automatic send_item(input c8ic_pkg::func_t f, input logic [11:0] a,
                           input logic [7:0] wd, input logic [4:0] rs,
                           input logic [15:0] keys, input logic [7:0] rnd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    address <= a;
    write_data <= wd;
    row_select <= rs;
    keys_pressed <= keys;
    random_value <= rnd;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [15:0] draw_keys();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly valid instructions; targets stay inside the loaded program.
  function automatic logic [15:0] make_instruction(input logic [11:0] base);
    logic [11:0] target;
    logic [3:0]  x, y;
    logic [7:0]  fcodes [0:10];
    fcodes = '{c8ic_pkg::KK_GETDELAY, c8ic_pkg::KK_WAITKEY, c8ic_pkg::KK_SETDELAY,
               c8ic_pkg::KK_SETSOUND, c8ic_pkg::KK_ADDI, c8ic_pkg::KK_FONT,
               c8ic_pkg::KK_BCD, c8ic_pkg::KK_STORE, c8ic_pkg::KK_LOAD, 8'h00, 8'hFF};
    target = base + 12'(2 * $urandom_range(0, 31));
    x = 4'($urandom);
    y = 4'($urandom);
    case ($urandom_range(0, 19))
      0: return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4095)) :
                ($urandom_range(0, 1) ? c8ic_pkg::OP_CLS : c8ic_pkg::OP_RET);
      1: return {4'h1, target};
      2: return {4'h2, target};
      3: return {4'h3, x, 8'($urandom)};
      4: return {4'h4, x, 8'($urandom)};
      5: return {4'h5, x, y, 4'($urandom)};
      6, 7: return {4'h6, x, 8'($urandom)};
      8: return {4'h7, x, 8'($urandom)};
      9, 10, 11: return {4'h8, x, y, 4'($urandom)};
      12: return {4'h9, x, y, 4'($urandom)};
      13: return {4'hA, 12'($urandom)};
      14: return {4'hB, target};
      15: return {4'hC, x, 8'($urandom)};
      16: return {4'hD, x, y, 4'($urandom)};
      17: return {4'hE, x, ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                ($urandom_range(0, 1) ? c8ic_pkg::KK_SKP : c8ic_pkg::KK_SKNP)};
      default: return {4'hF, x, fcodes[$urandom_range(0, 10)]};
    endcase
  endfunction

  task automatic load_word(input logic [11:0] a, input logic [15:0] w);
    send_item(c8ic_pkg::FUNC_WRITE, a, w[15:8], 5'($urandom), 16'($urandom),
              8'($urandom));
    send_item(c8ic_pkg::FUNC_WRITE, a + 12'd1, w[7:0], 5'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  // Hold the sender until every result is back and the core is quiet.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [11:0] starts [0:6];
    logic [11:0] fonts [0:6];
    logic [11:0] base;
    int          dice;
    starts = '{12'hFFE, 12'h000, 12'h200, 12'h7A1, 12'($urandom), 12'($urandom),
               12'($urandom)};
    fonts = '{12'h000, 12'hFFF, c8ic_pkg::FONT_RESET, 12'hFFB, 12'($urandom),
              12'($urandom), 12'($urandom)};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Edges of memory and screen, then a short program at the reset pc.
    send_item(c8ic_pkg::FUNC_WRITE, 12'hFFF, 8'hFF, 5'd31, 16'hFFFF, 8'hFF);
    send_item(c8ic_pkg::FUNC_WRITE, 12'h000, 8'h00, 5'd0, 16'h0000, 8'h00);
    send_item(c8ic_pkg::FUNC_READ, 12'hFFF, 8'h00, 5'd0, 16'h0000, 8'h00);
    send_item(c8ic_pkg::FUNC_READ, c8ic_pkg::FONT_RESET, 8'h00, 5'd0, 16'h0000, 8'h00);
    send_item(c8ic_pkg::FUNC_READ, c8ic_pkg::FONT_RESET + 12'd79, 8'h00, 5'd0, 16'h0000,
              8'h00);
    load_word(12'h200, 16'h60FF);
    load_word(12'h202, 16'h8F06);
    load_word(12'h204, 16'hF029);
    load_word(12'h206, 16'hD015);
    load_word(12'h208, 16'hF10A);
    repeat (4) send_item(c8ic_pkg::FUNC_EXEC, '0, '0, '0, 16'h8000, 8'h00);
    send_item(c8ic_pkg::FUNC_EXEC, '0, '0, '0, 16'h0000, 8'h00);
    send_item(c8ic_pkg::FUNC_EXEC, '0, '0, '0, 16'h0000, 8'h00);
    send_item(c8ic_pkg::FUNC_ROW, '0, '0, 5'd0, '0, '0);
    send_item(c8ic_pkg::FUNC_ROW, '0, '0, 5'd31, '0, '0);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      calm = (ph % 3 == 0);
      base = starts[ph];
      cfg_write(c8ic_pkg::REG_PROGRAM_START, base);
      cfg_write(c8ic_pkg::REG_FONT_BASE, fonts[ph]);
      @(negedge clk);
      cfg_we <= 1'b0;
      for (int k = 0; k < 32; k++) load_word(base + 12'(2 * k), make_instruction(base));
      for (int k = 0; k < 80; k++) begin
        dice = $urandom_range(0, 19);
        if (dice < 15)
          send_item(c8ic_pkg::FUNC_EXEC, 12'($urandom), 8'($urandom), 5'($urandom),
                    draw_keys(), 8'($urandom));
        else if (dice < 17)
          send_item(c8ic_pkg::FUNC_ROW, 12'($urandom), 8'($urandom), 5'($urandom),
                    16'($urandom), 8'($urandom));
        else if (dice < 19)
          send_item(c8ic_pkg::FUNC_READ, 12'($urandom), 8'($urandom), 5'($urandom),
                    16'($urandom), 8'($urandom));
        else
          send_item(c8ic_pkg::FUNC_WRITE, 12'($urandom), 8'($urandom), 5'($urandom),
                    16'($urandom), 8'($urandom));
      end
    end
    drain();

    $display("Ran %0d items across 7 loaded programs; %0d results checked.",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field errors", errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/c8ic_pkg.sv
design/c8ic_mem.sv
design/chip8_instruction_core.sv
test/c8ic_checker.sv
test/tb_chip8_instruction_core.sv
